// File: hdl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants
// Arctangent table, fixed-point constants and the CORDIC cell payload.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
    localparam logic [23:0] TURN_SCALE = 24'd10680707;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               flip;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_beat_t;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
        logic signed [33:0] v;
        unique case (idx)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/scattering_phase_average_core.sv
// ----------------------------------------------------------------------------
// scattering_phase_average_core: average of exp(i q.d) over a run of terms
// Phase front end, CORDIC cell chain, complex accumulators and divider.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one term per transfer: q vector, start and later
//   positions in s_axis_tdata, the run end flag in s_axis_tlast.
//   Each term enters a chain of CORDIC_STAGES+2 register stages (two phase
//   stages and the rotation cells) that advances one step per cycle while no
//   result waits; the last cell feeds the accumulators directly.
//   Ordinary terms are taken one per cycle while no run end is in flight and
//   no result waits. A term with tlast closes the run: the sums are divided by
//   the count in serial dividers, both quotients in parallel. After the
//   closing transfer the block stops taking terms until the average is
//   handed off.
//   The m_ channel carries avg_real and avg_imag; the result is held in an
//   output register until the receiver takes it, and the chain stalls
//   whole while a result waits, so no term is dropped.
//   Reset clears the sums, the count and every valid bit.
// ----------------------------------------------------------------------------
module scattering_phase_average_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int COUNT_BITS    = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // q_x, q_y, q_z, start_x, start_y, start_z, later_x, later_y, later_z
    input  logic [191:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // avg_real, avg_imag
    output logic [31:0]  m_axis_tdata
);
    import spa_pkg::*;

    logic advance, run_open_reg, in_go;
    logic div_start, div_done_r, div_done_i;
    logic signed [15:0] quo_r, quo_i;
    logic out_valid_reg;
    logic [31:0] out_data_reg;

    // phase stage 1: displacement times q, three products
    logic signed [15:0] qx, qy, qz;
    logic signed [24:0] dx, dy, dz;
    logic signed [41:0] px_reg, py_reg, pz_reg;
    logic p1_valid_reg, p1_last_reg;

    assign qx = s_axis_tdata[15:0];
    assign qy = s_axis_tdata[31:16];
    assign qz = s_axis_tdata[47:32];
    assign dx = 25'(signed'(s_axis_tdata[143:120])) - 25'(signed'(s_axis_tdata[71:48]));
    assign dy = 25'(signed'(s_axis_tdata[167:144])) - 25'(signed'(s_axis_tdata[95:72]));
    assign dz = 25'(signed'(s_axis_tdata[191:168])) - 25'(signed'(s_axis_tdata[119:96]));

    // hold terms while a run end is in flight or a result waits
    assign advance       = !out_valid_reg;
    assign s_axis_tready = advance && !run_open_reg;
    assign in_go         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= in_go;
            p1_last_reg  <= s_axis_tlast;
            px_reg <= 42'(qx * dx);
            py_reg <= 42'(qy * dy);
            pz_reg <= 42'(qz * dz);
        end
    end

    // phase stage 2: sum, scale to turns, fold into half turn
    logic signed [42:0] psum;
    logic [63:0] prod;
    logic signed [31:0] ang;
    logic fold;
    cordic_beat_t chain [0:CORDIC_STAGES];

    assign psum = 43'(px_reg) + 43'(py_reg) + 43'(pz_reg);
    assign prod = 64'(signed'(psum)) * 64'(TURN_SCALE);
    assign ang  = prod[47:16];
    assign fold = (ang > 32'sd1073741824) || (ang < -32'sd1073741824);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain[0].valid <= 1'b0;
        end else if (advance) begin
            chain[0].valid <= p1_valid_reg;
            chain[0].last  <= p1_last_reg;
            chain[0].flip  <= fold;
            chain[0].x     <= 34'(INV_GAIN);
            chain[0].y     <= '0;
            chain[0].z     <= fold ? 34'(signed'(ang + 32'sh80000000)) : 34'(ang);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cell
            spa_cordic_cell #(.STAGE(gi)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .advance(advance),
                .beat_in(chain[gi]), .beat_out(chain[gi+1])
            );
        end
    endgenerate

    // output of chain: negate, scale to Q1.15, saturate
    cordic_beat_t tail;
    logic signed [33:0] cx, cy, sx, sy;
    logic signed [15:0] cos_v, sin_v;

    assign tail = chain[CORDIC_STAGES];
    assign cx = tail.flip ? -tail.x : tail.x;
    assign cy = tail.flip ? -tail.y : tail.y;
    assign sx = cx >>> 15;
    assign sy = cy >>> 15;
    assign cos_v = (sx > 34'sd32767) ? 16'sh7FFF : (sx < -34'sd32768) ? 16'sh8000 : sx[15:0];
    assign sin_v = (sy > 34'sd32767) ? 16'sh7FFF : (sy < -34'sd32768) ? 16'sh8000 : sy[15:0];

    // accumulate
    logic [47:0] sum_r_reg, sum_i_reg, sum_r_next, sum_i_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic signed [47:0] hold_r_reg, hold_i_reg;
    logic [COUNT_BITS-1:0] hold_c_reg;
    logic take;

    assign take       = advance && tail.valid;
    assign sum_r_next = sum_r_reg + 48'(cos_v);
    assign sum_i_next = sum_i_reg + 48'(sin_v);
    assign cnt_next   = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
    assign div_start  = take && tail.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_r_reg    <= '0;
            sum_i_reg    <= '0;
            cnt_reg      <= '0;
            run_open_reg <= 1'b0;
        end else begin
            if (in_go && s_axis_tlast) run_open_reg <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) run_open_reg <= 1'b0;
            if (take) begin
                if (tail.last) begin
                    sum_r_reg <= '0;
                    sum_i_reg <= '0;
                    cnt_reg   <= '0;
                end else begin
                    sum_r_reg <= sum_r_next;
                    sum_i_reg <= sum_i_next;
                    cnt_reg   <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            hold_r_reg <= sum_r_next;
            hold_i_reg <= sum_i_next;
            hold_c_reg <= cnt_next;
        end
    end

    logic start_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) start_d_reg <= 1'b0;
        else          start_d_reg <= div_start;
    end

    spa_divider #(.COUNT_BITS(COUNT_BITS)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .start(start_d_reg),
        .dividend(hold_r_reg), .divisor(hold_c_reg),
        .done(div_done_r), .quotient(quo_r)
    );
    spa_divider #(.COUNT_BITS(COUNT_BITS)) u_div_i (
        .aclk(aclk), .aresetn(aresetn), .start(start_d_reg),
        .dividend(hold_i_reg), .divisor(hold_c_reg),
        .done(div_done_i), .quotient(quo_i)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (div_done_r && div_done_i) begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= {quo_i, quo_r};
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule

// File: hdl/spa_cordic_cell.sv
// ----------------------------------------------------------------------------
// spa_cordic_cell: one CORDIC rotation cell
// Rotate by the fixed arctangent of its stage and register the result.
// ----------------------------------------------------------------------------
module spa_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  spa_pkg::cordic_beat_t beat_in,
    output spa_pkg::cordic_beat_t beat_out
);
    import spa_pkg::*;

    cordic_beat_t beat_reg, beat_next;
    logic signed [33:0] xs, ys, ang;

    always_comb begin
        xs  = beat_in.x >>> STAGE;
        ys  = beat_in.y >>> STAGE;
        ang = atan_turn(5'(STAGE));
        beat_next = beat_in;
        if (!beat_in.z[33]) begin
            beat_next.x = beat_in.x - ys;
            beat_next.y = beat_in.y + xs;
            beat_next.z = beat_in.z - ang;
        end else begin
            beat_next.x = beat_in.x + ys;
            beat_next.y = beat_in.y - xs;
            beat_next.z = beat_in.z + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (advance) begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;
endmodule

// File: hdl/spa_divider.sv
// ----------------------------------------------------------------------------
// spa_divider: restoring signed divider
// Divide a 48 bit sum by the term count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spa_divider #(
    parameter int COUNT_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [47:0] dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic               done,
    output logic signed [15:0] quotient
);
    import spa_pkg::*;

    localparam int CNT_W = 6;

    logic [47:0]           mag_reg, mag_next;
    logic [COUNT_BITS:0]   rem_reg, rem_next;
    logic [COUNT_BITS-1:0] div_reg;
    logic                  neg_reg, busy_reg, done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COUNT_BITS:0]   trial;
    logic [48:0]           sq;

    always_comb begin
        trial    = {rem_reg[COUNT_BITS-1:0], mag_reg[47]};
        mag_next = {mag_reg[46:0], 1'b0};
        rem_next = trial;
        if (trial >= {1'b0, div_reg}) begin
            rem_next    = trial - {1'b0, div_reg};
            mag_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= dividend[47];
                mag_reg  <= dividend[47] ? 48'(-dividend) : 48'(dividend);
                rem_reg  <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                mag_reg <= mag_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(47)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        sq = neg_reg ? -{1'b0, mag_reg} : {1'b0, mag_reg};
        if ($signed(sq) > 49'sd32767)       quotient = 16'sh7FFF;
        else if ($signed(sq) < -49'sd32768) quotient = 16'sh8000;
        else                                quotient = sq[15:0];
    end

    assign done = done_reg;
endmodule

// File: tb/tb_scattering_phase_average_core.sv
// ----------------------------------------------------------------------------
// tb_scattering_phase_average_core: self-checking bench for the phase averager
// Streams runs of q/position terms with random gaps and stalls, predicts each
// run average with a bit-exact fixed-point model, and checks every result transfer.
// ----------------------------------------------------------------------------
module tb_scattering_phase_average_core;
    import spa_pkg::*;

    localparam int STAGES     = 16;
    localparam int CNT_BITS   = 32;
    localparam int LIMIT      = 1000000;

    typedef struct packed {
        logic        last;
        logic [191:0] data;
    } term_t;

    typedef struct packed {
        logic signed [15:0] avg_imag;
        logic signed [15:0] avg_real;
    } avg_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // q_x, q_y, q_z, start_x, start_y, start_z, later_x, later_y, later_z
    logic [191:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // avg_real, avg_imag
    logic [31:0]  m_axis_tdata;

    term_t pending_terms[$];
    avg_t  expected_avgs[$];
    int    error_count = 0;
    int    cycle_count = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    hold_off = 0;
    bit    stim_done = 1'b0;
    bit    in_taken = 1'b0;

    // running sums of the predictor, mirror of the block accumulators
    logic [47:0] acc_real = '0;
    logic [47:0] acc_imag = '0;
    longint      acc_count = 0;

    scattering_phase_average_core #(.CORDIC_STAGES(STAGES), .COUNT_BITS(CNT_BITS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // phase -> (cos, sin) in Q1.15, turns-based rotation CORDIC
    function automatic void rotate_phase(longint phase, output longint c, output longint s);
        logic [63:0] prod;
        longint      z, x, y, xs, ys;
        bit          flip;
        prod = 64'(phase) * 64'd10680707;
        z = longint'($signed(prod[47:16]));
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 1073741824 || z < -1073741824) begin
            z = longint'($signed(32'(z + 64'd2147483648)));
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_turn(5'(i)));
            end else begin
                x += ys; y -= xs; z += longint'(atan_turn(5'(i)));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = clip16(floor_shr(x, 15));
        s = clip16(floor_shr(y, 15));
    endfunction

    // fold one term into the sums; on the run end push the average
    function automatic void accumulate_term(term_t t);
        longint phase, c, s, sr, si;
        avg_t   a;
        phase = 0;
        for (int k = 0; k < 3; k++) begin
            phase += longint'($signed(t.data[16*k +: 16])) *
                     (longint'($signed(t.data[48 + 24*(k+3) +: 24])) -
                      longint'($signed(t.data[48 + 24*k +: 24])));
        end
        rotate_phase(phase, c, s);
        acc_real += 48'(c);
        acc_imag += 48'(s);
        if (acc_count < (64'd1 << CNT_BITS) - 1) acc_count++;
        if (t.last) begin
            sr = longint'($signed(acc_real));
            si = longint'($signed(acc_imag));
            a.avg_real = 16'(clip16(sr / acc_count));
            a.avg_imag = 16'(clip16(si / acc_count));
            expected_avgs.push_back(a);
            acc_real = '0; acc_imag = '0; acc_count = 0;
        end
    endfunction

    function automatic term_t make_term(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                                        logic [23:0] sx, logic [23:0] sy, logic [23:0] sz,
                                        logic [23:0] lx, logic [23:0] ly, logic [23:0] lz,
                                        logic last);
        term_t t;
        t.data = {lz, ly, lx, sz, sy, sx, qz, qy, qx};
        t.last = last;
        return t;
    endfunction

    function automatic logic [23:0] rand_pos(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed(24'($urandom_range(0, 4095)) - 24'd2048));
            default: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    initial begin
        int          run_len, mode;
        logic [23:0] s0, s1, s2;
        // directed: zero phase, extremes, huge phase wrap, single-term runs
        pending_terms.push_back(make_term(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        pending_terms.push_back(make_term(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h800000,
            24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1));
        pending_terms.push_back(make_term(16'h8000, 16'h8000, 16'h8000, 24'h800000,
            24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0));
        pending_terms.push_back(make_term(16'h8000, 16'h7FFF, 16'h8000, 24'h7FFFFF,
            24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b1));
        // quarter and half turns around the CORDIC fold points
        for (int k = 0; k < 8; k++) begin
            pending_terms.push_back(make_term(16'd4096, 0, 0, 0, 0, 0,
                24'(k * 804), 0, 0, 1'b0));
            pending_terms.push_back(make_term(16'hF000, 0, 0, 24'(k * 1608), 0, 0,
                0, 0, 0, k[0]));
        end
        pending_terms.push_back(make_term(16'hFFFF, 16'h0001, 16'h5555, 24'hAAAAAA,
            24'h555555, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h000001, 1'b1));
        // random runs: mostly short runs of near-range moves, some wild values
        while (pending_terms.size() < 640) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
            for (int k = 0; k < run_len; k++) begin
                mode = ($urandom_range(0, 9) < 6) ? 1 : (($urandom_range(0, 3) == 0) ? 2 : 0);
                s0 = rand_pos(0); s1 = rand_pos(0); s2 = rand_pos(0);
                pending_terms.push_back(make_term(16'($urandom), 16'($urandom),
                    16'($urandom), s0, s1, s2,
                    (mode == 1) ? s0 + rand_pos(1) : rand_pos(mode),
                    (mode == 1) ? s1 + rand_pos(1) : rand_pos(mode),
                    (mode == 1) ? s2 + rand_pos(1) : rand_pos(mode),
                    k == run_len - 1));
            end
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;
    end

    // note an input transfer at the edge where it happens
    always @(posedge aclk) begin
        in_taken <= aresetn && s_axis_tvalid && s_axis_tready;
    end

    // driver: present terms at the falling edge, advance on accepted transfer
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                accumulate_term({s_axis_tlast, s_axis_tdata});
                void'(pending_terms.pop_front());
                send_gap <= ($urandom_range(0, 3) == 0)
                    ? (($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 3)) : 0;
                s_axis_tvalid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_terms.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_terms[0].data;
                s_axis_tlast <= pending_terms[0].last;
            end else begin
                s_axis_tvalid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // receiver readiness: random stalls, one long hold-off mid-run and a stall-free window
    always @(negedge aclk) begin
        if (aresetn) begin
            if (cycle_count == 3000) begin
                hold_off <= 600;
                m_axis_tready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (cycle_count > 20000 && cycle_count < 23000) begin
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                        : $urandom_range(1, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: check each result transfer against the oldest prediction
    always @(posedge aclk) begin
        avg_t got, want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_avgs.size() == 0) begin
                report_mismatch("unexpected result avg_real", got.avg_real, 0);
            end else begin
                want = expected_avgs.pop_front();
                if (got.avg_real !== want.avg_real)
                    report_mismatch("avg_real", got.avg_real, want.avg_real);
                if (got.avg_imag !== want.avg_imag)
                    report_mismatch("avg_imag", got.avg_imag, want.avg_imag);
            end
        end
    end

    // end of run: drain, settle, then judge
    initial begin
        wait (stim_done && expected_avgs.size() == 0);
        repeat (STAGES + 80) @(posedge aclk);
        if (error_count == 0 && expected_avgs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("Timeout at cycle %0d", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
